// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// A trigger that must be followed by a consequence in the next clock cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/shabsh_pkg.sv
// Package of the SHA-256 byte stream hasher: types, constants and round functions.
`timescale 1ns / 1ps
`default_nettype none

package shabsh_pkg;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   // One input item as it travels from the front queue to the engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       final_item;
   } item_type;

   // Digest hand-over from the engine to the result queue; words[i] is H(i).
   typedef struct packed {
      logic             load;
      logic [7:0][31:0] words;
   } digest_load_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } eng_state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] initial_h(input logic [2:0] i);
      case (i)
         3'd0: initial_h = 32'h6a09e667;
         3'd1: initial_h = 32'hbb67ae85;
         3'd2: initial_h = 32'h3c6ef372;
         3'd3: initial_h = 32'ha54ff53a;
         3'd4: initial_h = 32'h510e527f;
         3'd5: initial_h = 32'h9b05688c;
         3'd6: initial_h = 32'h1f83d9ab;
         default: initial_h = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      case (i)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher.
// The message enters as items on the req_ queue port: one byte per item, a flag
// marking whether the byte is present, and a flag closing the message. An item is
// taken when req_push is high and req_full is low; a two-item front queue keeps
// accepting while the engine works. The engine shifts each message byte into its block
// buffer, and each full 64-byte block then takes 64 rounds of the single round unit
// and a step that folds the result into the chaining words. A final item adds padding
// bytes (up to 64, or up to 72 when the length spills into an extra block), one or two
// more compressions, and the hand-over of the digest.
// The digest leaves on the rsp_ queue port as eight 32-bit words, H0 first, while
// rsp_empty is low; rsp_pop takes one word. If the receiver stalls, the engine stops
// before the hand-over of the next digest and the front queue fills, raising req_full.
// After a synchronous reset both queues are empty and the chaining words hold the
// initial hash values.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_final_item,
   input  wire logic        req_push,
   output logic             req_full,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop
);

   shabsh_pkg::item_type        item;
   shabsh_pkg::digest_load_type digest;
   logic                        item_avail;
   logic                        item_pop;
   logic                        out_busy;

   shabsh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_final_item (req_final_item),
      .req_push       (req_push),
      .req_full       (req_full),
      .item_avail     (item_avail),
      .item           (item),
      .item_pop       (item_pop)
   );

   shabsh_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_avail (item_avail),
      .item       (item),
      .item_pop   (item_pop),
      .out_busy   (out_busy),
      .digest     (digest)
   );

   shabsh_digest_out u_digest_out (
      .clock           (clock),
      .reset           (reset),
      .digest          (digest),
      .out_busy        (out_busy),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

endmodule

`default_nettype wire

// File: rtl/shabsh_front.sv
// Front queue of the hasher: accepts items, drops empty ones and holds two for the engine.
`timescale 1ns / 1ps
`default_nettype none

module shabsh_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_byte_valid,
   input  wire logic                req_final_item,
   input  wire logic                req_push,
   output logic                     req_full,
   output logic                     item_avail,
   output shabsh_pkg::item_type     item,
   input  wire logic                item_pop
);

   shabsh_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       keep;
   logic       do_pop;

   // An item with neither a byte nor the final mark changes nothing and is dropped here.
   assign req_full   = (count_ff == 2'd2);
   assign accept     = req_push && !req_full;
   assign keep       = accept && (req_byte_valid || req_final_item);
   assign item_avail = (count_ff != 2'd0);
   assign do_pop     = item_pop && item_avail;
   assign item       = q_ff[rd_ptr_ff];

   // Pointer and fill count of the queue.
   always_comb begin
      wr_ptr_in = keep ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, keep} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[wr_ptr_ff] <= '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                              final_item: req_final_item};
      end
   end

endmodule

`default_nettype wire

// File: rtl/shabsh_engine.sv
// Back part of the hasher: block buffer, padding sequencer and the SHA-256 round unit.
`timescale 1ns / 1ps
`default_nettype none

module shabsh_engine (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_avail,
   input  wire shabsh_pkg::item_type    item,
   output logic                         item_pop,
   input  wire logic                    out_busy,
   output shabsh_pkg::digest_load_type  digest
);

   shabsh_pkg::eng_state_type state_ff, state_in;

   logic [31:0] blk_ff   [16];
   logic [31:0] blk_in   [16];
   logic [31:0] var_ff   [8];
   logic [31:0] var_in   [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic        closing_ff, closing_in;
   logic        pad_first_ff, pad_first_in;
   logic        len_block_ff, len_block_in;
   logic        finish_ff, finish_in;

   logic [7:0]  pad_byte;
   logic [7:0]  len_byte;
   logic [63:0] len_shifted;
   logic [7:0]  shift_byte;
   logic        shift_en;
   logic [31:0] t1, t2, w_next;

   // Byte of the padding tail: the pad mark, zero fill or the big-endian bit length.
   assign len_shifted = bitlen_ff >> {~fill_ff[2:0], 3'b000};
   assign len_byte    = len_shifted[7:0];
   always_comb begin
      if (pad_first_ff) begin
         pad_byte = shabsh_pkg::PAD_BYTE;
      end else if (len_block_ff && (fill_ff >= shabsh_pkg::LEN_POS)) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign shift_byte = (state_ff == shabsh_pkg::ST_PAD) ? pad_byte : item.data_byte;
   assign shift_en   = (state_ff == shabsh_pkg::ST_PAD) ||
                       ((state_ff == shabsh_pkg::ST_IDLE) && item_avail && item.byte_valid);
   assign item_pop   = (state_ff == shabsh_pkg::ST_IDLE) && item_avail;

   // Round arithmetic; blk_ff[0] holds the schedule word of the current round.
   assign t1 = var_ff[7] + shabsh_pkg::big_sigma1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + shabsh_pkg::round_k(round_ff) + blk_ff[0];
   assign t2 = shabsh_pkg::big_sigma0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   assign w_next = shabsh_pkg::small_sigma1(blk_ff[14]) + blk_ff[9]
                 + shabsh_pkg::small_sigma0(blk_ff[1]) + blk_ff[0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shabsh_pkg::ST_IDLE: begin
            if (item_avail) begin
               if (item.byte_valid && (fill_ff == shabsh_pkg::LAST_POS)) begin
                  state_in = shabsh_pkg::ST_ROUND;
               end else if (item.final_item) begin
                  state_in = shabsh_pkg::ST_PAD;
               end
            end
         end
         shabsh_pkg::ST_PAD: begin
            if (fill_ff == shabsh_pkg::LAST_POS) begin
               state_in = shabsh_pkg::ST_ROUND;
            end
         end
         shabsh_pkg::ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = shabsh_pkg::ST_UPDATE;
            end
         end
         shabsh_pkg::ST_UPDATE: begin
            if (finish_ff) begin
               state_in = shabsh_pkg::ST_EMIT;
            end else if (closing_ff) begin
               state_in = shabsh_pkg::ST_PAD;
            end else begin
               state_in = shabsh_pkg::ST_IDLE;
            end
         end
         shabsh_pkg::ST_EMIT: begin
            if (!out_busy) begin
               state_in = shabsh_pkg::ST_IDLE;
            end
         end
         default: state_in = shabsh_pkg::ST_IDLE;
      endcase
   end

   // Datapath and control values for each state.
   always_comb begin
      blk_in       = blk_ff;
      var_in       = var_ff;
      chain_in     = chain_ff;
      bitlen_in    = bitlen_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      closing_in   = closing_ff;
      pad_first_in = pad_first_ff;
      len_block_in = len_block_ff;
      finish_in    = finish_ff;
      digest.load  = 1'b0;
      for (int i = 0; i < 8; i++) begin
         digest.words[i] = chain_ff[i];
      end

      // A message byte or a padding byte shifts the whole block left by one byte.
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            blk_in[i] = {blk_ff[i][23:0], blk_ff[i + 1][31:24]};
         end
         blk_in[15] = {blk_ff[15][23:0], shift_byte};
         fill_in    = fill_ff + 6'd1;
         if (fill_ff == shabsh_pkg::LAST_POS) begin
            var_in   = chain_ff;
            round_in = 6'd0;
         end
      end

      unique case (state_ff)
         shabsh_pkg::ST_IDLE: begin
            if (item_avail) begin
               if (item.byte_valid) begin
                  bitlen_in = bitlen_ff + 64'd8;
               end
               if (item.final_item) begin
                  closing_in   = 1'b1;
                  pad_first_in = 1'b1;
               end
            end
         end
         shabsh_pkg::ST_PAD: begin
            pad_first_in = 1'b0;
            // The length fits behind the pad mark only if the mark lands before byte 56.
            if (pad_first_ff && (fill_ff < shabsh_pkg::LEN_POS)) begin
               len_block_in = 1'b1;
            end
            if (fill_ff == shabsh_pkg::LAST_POS) begin
               finish_in = !pad_first_ff && len_block_ff;
            end
         end
         shabsh_pkg::ST_ROUND: begin
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               blk_in[i] = blk_ff[i + 1];
            end
            blk_in[15] = w_next;
            round_in   = round_ff + 6'd1;
         end
         shabsh_pkg::ST_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + var_ff[i];
            end
            // A closing block without the length ends the padding; the next block carries the length.
            if (closing_ff && !finish_ff) begin
               len_block_in = 1'b1;
            end
            round_in = 6'd0;
         end
         shabsh_pkg::ST_EMIT: begin
            if (!out_busy) begin
               digest.load = 1'b1;
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = shabsh_pkg::initial_h(3'(i));
               end
               bitlen_in    = 64'd0;
               closing_in   = 1'b0;
               finish_in    = 1'b0;
               len_block_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers and chaining words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shabsh_pkg::ST_IDLE;
         bitlen_ff    <= 64'd0;
         fill_ff      <= 6'd0;
         round_ff     <= 6'd0;
         closing_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         len_block_ff <= 1'b0;
         finish_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= shabsh_pkg::initial_h(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         bitlen_ff    <= bitlen_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         closing_ff   <= closing_in;
         pad_first_ff <= pad_first_in;
         len_block_ff <= len_block_in;
         finish_ff    <= finish_in;
         chain_ff     <= chain_in;
      end
   end

   // Block window and working variables carry payload only.
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      var_ff <= var_in;
   end

endmodule

`default_nettype wire

// File: rtl/shabsh_digest_out.sv
// Result queue of the hasher: holds one digest and hands it out word by word.
`timescale 1ns / 1ps
`default_nettype none

module shabsh_digest_out (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire shabsh_pkg::digest_load_type digest,
   output logic                             out_busy,
   output logic [31:0]                      rsp_digest_word,
   output logic [2:0]                       rsp_word_index,
   output logic                             rsp_last_word,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop
);

   logic [7:0][31:0] words_ff, words_in;
   logic [2:0]       idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             do_pop;

   assign do_pop          = rsp_pop && busy_ff;
   assign out_busy        = busy_ff;
   assign rsp_empty       = !busy_ff;
   assign rsp_digest_word = words_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   // A load fills the queue; each pop moves the next word to the front.
   always_comb begin
      words_in = words_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (digest.load) begin
         words_in = digest.words;
         idx_in   = 3'd0;
         busy_in  = 1'b1;
      end else if (do_pop) begin
         words_in = {32'd0, words_ff[7:1]};
         idx_in   = idx_ff + 3'd1;
         if (idx_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

`default_nettype wire

// File: rtl/shabsh_checker.sv
// Port checker of the hasher and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shabsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop
);

   // The last flag marks exactly the eighth word of a digest.
   `ASSERT_ALWAYS(a_last_flag, clock, reset, rsp_empty || (rsp_last_word == (rsp_word_index == 3'd7)))

   // Words of one digest follow each other without a gap.
   `ASSERT_NEXT(a_word_step, clock, reset, rsp_pop && !rsp_empty && !rsp_last_word, !rsp_empty && (rsp_word_index == $past(rsp_word_index) + 3'd1))

   // Taking the last word empties the result side.
   `ASSERT_NEXT(a_last_drains, clock, reset, rsp_pop && !rsp_empty && rsp_last_word, rsp_empty)

   // Reset leaves both sides empty.
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, rsp_empty && !req_full)

endmodule

bind sha256_byte_stream_hasher_core shabsh_checker u_checker (.*);

`default_nettype wire

// File: sim/digest_checker.sv
// Checker of the SHA-256 byte stream hasher: predicts the digest words and compares them.
`timescale 1ns / 1ps

module digest_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_final_item,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [31:0] rsp_digest_word,
   input  wire logic [2:0]  rsp_word_index,
   input  wire logic        rsp_last_word,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   output int               fail_count,
   output int               words_pending
);

   // One expected digest word.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]     chain [8];
   logic [7:0]      block_bytes [64];
   logic [63:0]     msg_bits;
   logic [5:0]      fill;
   digest_word_type expected_words [$];

   assign words_pending = expected_words.size();

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Compresses the buffered block into the chaining words.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   // Appends one byte and compresses when the block is full.
   task automatic append_byte(input logic [7:0] b);
      block_bytes[fill] = b;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress_block();
   endtask

   task automatic hash_item(input logic [7:0] b, input logic valid, input logic fin);
      digest_word_type d;
      if (valid) begin
         msg_bits += 64'd8;
         append_byte(b);
      end
      if (fin) begin
         append_byte(8'h80);
         while (fill != 6'd56) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(msg_bits[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            d.word = chain[i];
            d.index = 3'(i);
            d.last = (i == 7);
            expected_words.insert(expected_words.size(), d);
            chain[i] = START_HASH[i];
         end
         msg_bits = '0;
      end
   endtask

   // Each mismatch prints one line and is counted.
   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      msg_bits = '0;
      fill = '0;
      for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
   end

   // Watch both channels at every rising edge.
   always @(posedge clock) begin
      digest_word_type e;
      if (!reset) begin
         if (req_push && !req_full) hash_item(req_data_byte, req_byte_valid, req_final_item);
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected word %h", rsp_digest_word));
            end else begin
               e = expected_words.pop_front();
               if (rsp_digest_word !== e.word)
                  report($sformatf("word %h, expected %h", rsp_digest_word, e.word));
               if (rsp_word_index !== e.index)
                  report($sformatf("index %0d, expected %0d", rsp_word_index, e.index));
               if (rsp_last_word !== e.last)
                  report($sformatf("last %b, expected %b", rsp_last_word, e.last));
            end
         end
      end
   end

endmodule

// File: sim/testbench.sv
// Top of the hasher testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_final_item;
   logic        req_push;
   logic        req_full;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_empty;
   logic        rsp_pop;
   int          fail_count;
   int          words_pending;
   int          send_idle_pct;
   int          take_idle_pct;
   logic        hold_off;
   int          quiet_cycles;

   sha256_byte_stream_hasher_core u_dut (.*);
   digest_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offers one item and waits until it is taken; push stays high for a following item.
   task automatic send_item(input logic [7:0] b, input logic valid, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_data_byte <= b;
      req_byte_valid <= valid;
      req_final_item <= fin;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   // Withdraws the offer after the last item of a stretch.
   task automatic stop_sending();
      req_push <= 1'b0;
      @(negedge clock);
   endtask

   // A message of n random bytes, closed in about half the cases by a byte-and-final item.
   task automatic send_message(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == n - 1) && $urandom_range(1));
      end
      if (n == 0 || !req_final_item) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic random_phase(input int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0: n = $urandom_range(119, 56);
            1, 2: n = $urandom_range(64, 52);
            default: n = $urandom_range(12);
         endcase
         if (n > items - sent - 1) n = items - sent - 1;
         send_message(n);
         sent += n + 1;
      end
   endtask

   // Receiver: random pops, or a long hold-off when asked.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= !hold_off && ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted item or word.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_data_byte = '0;
      req_byte_valid = 1'b0;
      req_final_item = 1'b0;
      req_push = 1'b0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, lone empty item, extreme bytes, short messages.
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_message(3);
      send_message(5);
      stop_sending();
      wait_drained();

      // The receiver holds off while the sender fills the front queue.
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            send_message(2);
            send_message(1);
            send_message(3);
            send_message(0);
            stop_sending();
         end
      join
      wait_drained();

      send_message(55);
      send_message(56);
      send_message(64);
      stop_sending();
      wait_drained();

      send_idle_pct = 29;
      take_idle_pct = 61;
      random_phase(45);
      send_idle_pct = 61;
      take_idle_pct = 29;
      random_phase(45);
      send_idle_pct = 0;
      take_idle_pct = 0;
      random_phase(35);
      stop_sending();

      wait_drained();
      repeat (300) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
